// ===== src/kda_pkg.sv =====
`timescale 1ns / 1ps

package kda_pkg;

   localparam int KEY_COUNT_DEF = 16;
   localparam int KEY_W         = 4;
   localparam int HIST_W        = 4;
   localparam int TICK_W        = 8;

   localparam logic [HIST_W-1:0] HIST_ALL_ONES = 4'hf;
   localparam logic [TICK_W-1:0] KILL_MARK     = 8'd250;
   localparam logic [TICK_W-1:0] TICK_LONG     = 8'd30;
   localparam logic [TICK_W-1:0] TICK_STEP16   = 8'd48;
   localparam logic [TICK_W-1:0] TICK_STEP8    = 8'd128;
   localparam logic [TICK_W-1:0] TICK_STEP4    = 8'd208;
   localparam logic [TICK_W-1:0] TICK_WRAP     = 8'd206;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_KILL = 1'b1;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_FIRST  = 3'd1,
      EV_LONG   = 3'd2,
      EV_REPEAT = 3'd3,
      EV_BREAK  = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [HIST_W-1:0] history;
      logic [TICK_W-1:0] ticks;
   } entry_type;

endpackage

// ===== src/kda_req_if.sv =====
`timescale 1ns / 1ps

interface kda_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [3:0] key_index;
   logic       pressed;

   modport source (output valid, output operation, output key_index, output pressed,
                   input ready);
   modport sink (input valid, input operation, input key_index, input pressed,
                 output ready);
endinterface

// ===== src/kda_rsp_if.sv =====
`timescale 1ns / 1ps

interface kda_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [3:0] event_key;
   logic       key_held;

   modport source (output valid, output event_kind, output event_key, output key_held,
                   input ready);
   modport sink (input valid, input event_kind, input event_key, input key_held,
                 output ready);
endinterface

// ===== src/kda_store.sv =====
`timescale 1ns / 1ps

module kda_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  kda_pkg::entry_type wr_data,
   output kda_pkg::entry_type rd_data
);
   import kda_pkg::*;

   entry_type        mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   entry_type        mem_q_ff;
   logic             hit_q_ff;
   logic             fwd_q_ff;
   entry_type        fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // a write landing on the same edge as the read is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         hit_q_ff    <= valid_ff[rd_addr];
         fwd_q_ff    <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (fwd_q_ff) begin
         rd_data = fwd_data_ff;
      end else if (hit_q_ff) begin
         rd_data = mem_q_ff;
      end else begin
         rd_data = '0;
      end
   end
endmodule

// ===== src/kda_update.sv =====
`timescale 1ns / 1ps

module kda_update (
   input  logic                     operation,
   input  logic                     pressed,
   input  kda_pkg::entry_type       entry_cur,
   output kda_pkg::entry_type       entry_nxt,
   output kda_pkg::event_kind_type  event_kind,
   output logic                     key_held
);
   import kda_pkg::*;

   logic [HIST_W-1:0] hist_now;
   logic [TICK_W-1:0] cnt_base;
   logic [TICK_W:0]   cnt_inc;
   logic [TICK_W-1:0] cnt_nxt;
   event_kind_type    ev;

   always_comb begin
      hist_now = {entry_cur.history[HIST_W-2:0], pressed};
      cnt_base = entry_cur.ticks;
      ev       = EV_NONE;

      if (entry_cur.history != hist_now) begin
         if (hist_now == '0) begin
            if (entry_cur.ticks < KILL_MARK) begin
               ev = EV_BREAK;
            end
         end else if (hist_now == HIST_ALL_ONES) begin
            cnt_base = '0;
         end
      end

      cnt_inc = {1'b0, cnt_base} + 9'd1;
      cnt_nxt = cnt_base;
      if (hist_now == HIST_ALL_ONES) begin
         cnt_nxt = cnt_inc[TICK_W-1:0];
         if (cnt_inc >= {1'b0, KILL_MARK}) begin
            cnt_nxt = KILL_MARK;
         end else if (cnt_inc == 9'd1) begin
            ev = EV_FIRST;
         end else if (cnt_inc == {1'b0, TICK_LONG}) begin
            ev = EV_LONG;
         end else if (cnt_inc <= {1'b0, TICK_STEP16}) begin
            if (cnt_inc[3:0] == 4'd0) ev = EV_REPEAT;
         end else if (cnt_inc <= {1'b0, TICK_STEP8}) begin
            if (cnt_inc[2:0] == 3'd0) ev = EV_REPEAT;
         end else if (cnt_inc <= {1'b0, TICK_STEP4}) begin
            if (cnt_inc[1:0] == 2'd0) ev = EV_REPEAT;
            if (cnt_inc == {1'b0, TICK_STEP4}) cnt_nxt = TICK_WRAP;
         end
      end

      if (operation == OP_KILL) begin
         entry_nxt.history = entry_cur.history;
         entry_nxt.ticks   = KILL_MARK;
         event_kind        = EV_NONE;
         key_held          = (entry_cur.history == HIST_ALL_ONES);
      end else begin
         entry_nxt.history = hist_now;
         entry_nxt.ticks   = cnt_nxt;
         event_kind        = ev;
         key_held          = (hist_now == HIST_ALL_ONES);
      end
   end
endmodule

// ===== src/key_debounce_autorepeat.sv =====
`timescale 1ns / 1ps

// Multi-key debouncer with first-press, long-press and autorepeat events.
// req channel: one item per scan tick of one key (operation = tick with the
// raw level in pressed, or kill to silence that key until its next press).
// rsp channel: exactly one result per request, in request order: the event
// kind (none when nothing happens), the key and its debounced held level.
// Per-key history and held-tick count live in one single-port-read memory;
// the entry is read on the request transfer, updated in the next cycle and
// written back as the result is loaded into the output register.
// The read data is registered in the memory wrapper, the result in the output register.
// Throughput: one request per cycle unless rsp stalls; a back-to-back request
// to the same key gets the written-back entry by a forward path in the store.
// Reset clears per-entry valid bits so every key reads as history 0, count 0;
// no clearing sweep is needed and requests are taken right after reset.
// When rsp stalls, the output register holds, one more request is taken
// into the update stage, and req.ready then drops until rsp moves.
// Keys at or above KEY_COUNT leave all state alone and answer none / 0.
module key_debounce_autorepeat #(
   parameter int KEY_COUNT = kda_pkg::KEY_COUNT_DEF
) (
   input logic       clock,
   input logic       reset,
   kda_req_if.sink   req,
   kda_rsp_if.source rsp
);
   import kda_pkg::*;

   localparam int ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   logic              req_xfer;
   logic              s1_adv;
   logic              s1_valid_ff;
   logic              s1_op_ff;
   logic              s1_pressed_ff;
   logic [KEY_W-1:0]  s1_key_ff;
   logic              s1_inrange_ff;
   logic              wr_en;
   entry_type         entry_cur;
   entry_type         entry_nxt;
   event_kind_type    upd_kind;
   logic              upd_held;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_kind_ff;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic              rsp_held_ff;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req.valid && req.ready;
   assign wr_en     = s1_adv && s1_inrange_ff;

   kda_store #(
      .DEPTH  (KEY_COUNT),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_addr (ADDR_W'(req.key_index)),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(s1_key_ff)),
      .wr_data (entry_nxt),
      .rd_data (entry_cur)
   );

   kda_update u_update (
      .operation  (s1_op_ff),
      .pressed    (s1_pressed_ff),
      .entry_cur  (entry_cur),
      .entry_nxt  (entry_nxt),
      .event_kind (upd_kind),
      .key_held   (upd_held)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff      <= req.operation;
         s1_pressed_ff <= req.pressed;
         s1_key_ff     <= req.key_index;
         s1_inrange_ff <= (int'(req.key_index) < KEY_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp.ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_key_ff <= s1_key_ff;
         if (s1_inrange_ff) begin
            rsp_kind_ff <= upd_kind;
            rsp_held_ff <= upd_held;
         end else begin
            rsp_kind_ff <= EV_NONE;
            rsp_held_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_kind = rsp_kind_ff;
   assign rsp.event_key  = rsp_key_ff;
   assign rsp.key_held   = rsp_held_ff;

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (int'(s1_key_ff) < KEY_COUNT))
      else $error("write-back for a key outside the store");

   a_adv_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("update stage advanced without loading the output register");

   a_out_of_range_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (int'(rsp_key_ff) >= KEY_COUNT))
         |-> (rsp_kind_ff == EV_NONE) && !rsp_held_ff)
      else $error("event reported for a key outside the store");

   a_held_no_break: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_held_ff) |-> (rsp_kind_ff != EV_BREAK))
      else $error("break reported while key still held");
endmodule
